FILE: sv/apd_pkg.sv
// Shared types and codes for the aging priority dispatcher.
// No dependencies; imported by aging_priority_dispatcher.
package apd_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned RATING_W = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;

  // rating divisor and the elapsed width beyond which the rating always saturates
  localparam int unsigned RATE_DIV  = 10;
  localparam int unsigned DIV_MAX_W = 36;

  localparam logic [CMD_W-1:0] CMD_POST     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POSTED     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FINISHED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_ID     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  kernel_id;
    logic [MS_W-1:0]  now_ms;
  } apd_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     chosen_id;
    logic [RATING_W-1:0] rating;
  } apd_out_t;

endpackage

FILE: sv/aging_priority_dispatcher.sv
// Mailbox dispatcher: post, finish and aged-priority dispatch over ENTRIES mailboxes.
// Depends on apd_pkg. A bad id or unused command is answered straight from idle; post or
// finish after a registered mailbox read; dispatch after a scan of all mailboxes (one rated
// per cycle through a four-stage rating unit), a drain of that unit and a commit. busy stays
// high until the result beat. After reset a clearing pass zeroes the mailbox memory; busy is
// high meanwhile. The receiver cannot stall: each result beat lasts one cycle.
module aging_priority_dispatcher
  import apd_pkg::*;
#(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  apd_in_t         item_i,
  input  logic            cfg_we_i,
  input  logic [ID_W-1:0] cfg_wdata_i,
  output logic            result_valid_o,
  output apd_out_t        result_o
);

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned WORD_W = 1 + COUNT_WIDTH + TIME_WIDTH;
  localparam int unsigned DW     = (TIME_WIDTH < DIV_MAX_W) ? TIME_WIDTH : DIV_MAX_W;
  localparam int unsigned QW     = DW - 3;
  localparam logic [DW-1:0] RECIP =
    DW'(((64'd1 << (DW + 3)) + 64'(RATE_DIV) - 64'd1) / 64'(RATE_DIV));
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_ACCESS = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DRAIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [IDX_W-1:0]      ptr_q, ptr_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;
  logic [ID_W-1:0]       base_q;

  logic [WORD_W-1:0] mem_q [ENTRIES];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  logic                   rd_busy;
  logic [COUNT_WIDTH-1:0] rd_cnt, cnt_inc;
  logic [TIME_WIDTH-1:0]  rd_time;

  logic [ID_W-1:0]  in_off;
  logic             in_range;
  logic [IDX_W-1:0] in_idx;

  // rating pipeline
  logic                   p0_vld_q, p1_vld_q, p2_vld_q, p3_vld_q;
  logic [IDX_W-1:0]       p0_idx_q, p1_idx_q, p2_idx_q, p3_idx_q;
  logic                   p1_elig_q, p2_elig_q, p3_elig_q;
  logic [COUNT_WIDTH-1:0] p1_cnt_q, p2_cnt_q, p3_cnt_q;
  logic [TIME_WIDTH-1:0]  p1_time_q, p2_time_q, p3_time_q;
  logic [TIME_WIDTH-1:0]  p1_elapsed_q;
  logic [2*DW-1:0]        p2_prod_q;
  logic                   p2_sat_q;
  logic [RATING_W-1:0]    p3_rate_q;
  logic [QW-1:0]          quot;
  logic [RATING_W+1:0]    rate_sum;
  logic                   pipe_busy;

  logic                   found_q, found_clr, best_upd;
  logic [RATING_W-1:0]    best_rate_q;
  logic [IDX_W-1:0]       best_idx_q;
  logic [COUNT_WIDTH-1:0] best_cnt_q, best_cnt_dec;
  logic [TIME_WIDTH-1:0]  best_time_q;

  logic     res_vld_q, res_vld_d;
  apd_out_t res_q, res_d;

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  assign in_off   = item_i.kernel_id - base_q;
  assign in_range = (in_off < ID_W'(ENTRIES));
  assign in_idx   = in_off[IDX_W-1:0];

  assign rd_busy = rdata_q[WORD_W-1];
  assign rd_cnt  = rdata_q[TIME_WIDTH +: COUNT_WIDTH];
  assign rd_time = rdata_q[TIME_WIDTH-1:0];
  assign cnt_inc = rd_cnt + 1'b1;
  assign best_cnt_dec = best_cnt_q - 1'b1;

  assign mem_raddr = (state_q == S_SCAN) ? ptr_q : in_idx;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign quot      = p2_prod_q[2*DW-1 -: QW];
  assign rate_sum  = (RATING_W + 2)'(p2_cnt_q) + (RATING_W + 2)'(quot);
  assign pipe_busy = p0_vld_q | p1_vld_q | p2_vld_q | p3_vld_q;
  assign best_upd  = p3_vld_q && p3_elig_q && (!found_q || (p3_rate_q > best_rate_q));

  always_ff @(posedge clk_i) begin
    p0_idx_q     <= ptr_q;
    p1_idx_q     <= p0_idx_q;
    p1_elig_q    <= !rd_busy && (rd_cnt != '0);
    p1_cnt_q     <= rd_cnt;
    p1_time_q    <= rd_time;
    p1_elapsed_q <= now_q - rd_time;
    p2_idx_q     <= p1_idx_q;
    p2_elig_q    <= p1_elig_q;
    p2_cnt_q     <= p1_cnt_q;
    p2_time_q    <= p1_time_q;
    p2_sat_q     <= ((p1_elapsed_q >> DW) != '0);
    p2_prod_q    <= (2*DW)'(p1_elapsed_q[DW-1:0]) * (2*DW)'(RECIP);
    p3_idx_q     <= p2_idx_q;
    p3_elig_q    <= p2_elig_q;
    p3_cnt_q     <= p2_cnt_q;
    p3_time_q    <= p2_time_q;
    p3_rate_q    <= (p2_sat_q || (|rate_sum[RATING_W+1 -: 2])) ? '1 : rate_sum[RATING_W-1:0];
    if (best_upd) begin
      best_rate_q <= p3_rate_q;
      best_idx_q  <= p3_idx_q;
      best_cnt_q  <= p3_cnt_q;
      best_time_q <= p3_time_q;
    end
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    now_q <= now_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    now_d     = now_q;
    found_clr = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = '0;
    res_vld_d = 1'b0;
    res_d     = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
        if (ptr_q == LAST_IDX) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_d = item_i.cmd;
          idx_d = in_idx;
          now_d = TIME_WIDTH'(item_i.now_ms);
          case (item_i.cmd) inside
            CMD_POST, CMD_FINISH: begin
              if (in_range) begin
                state_d = S_ACCESS;
              end else begin
                res_vld_d    = 1'b1;
                res_d.status = ST_BAD_ID;
              end
            end
            CMD_DISPATCH: begin
              ptr_d     = '0;
              found_clr = 1'b1;
              state_d   = S_SCAN;
            end
            default: begin
              res_vld_d    = 1'b1;
              res_d.status = ST_NONE;
            end
          endcase
        end
      end
      S_ACCESS: begin
        mem_waddr = idx_q;
        res_vld_d = 1'b1;
        state_d   = S_IDLE;
        if (cmd_q == CMD_POST) begin
          if (&rd_cnt) begin
            res_d.status = ST_FULL;
          end else begin
            mem_we       = 1'b1;
            mem_wdata    = {rd_busy, cnt_inc, now_q};
            res_d.status = ST_POSTED;
          end
        end else begin
          mem_we       = 1'b1;
          mem_wdata    = {1'b0, rd_cnt, rd_time};
          res_d.status = ST_FINISHED;
        end
      end
      S_SCAN: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == LAST_IDX) begin
          ptr_d   = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          res_vld_d = 1'b1;
          state_d   = S_IDLE;
          if (found_q) begin
            mem_we          = 1'b1;
            mem_waddr       = best_idx_q;
            mem_wdata       = {1'b1, best_cnt_dec, best_time_q};
            res_d.status    = ST_DISPATCHED;
            res_d.chosen_id = base_q + ID_W'(best_idx_q);
            res_d.rating    = best_rate_q;
          end else begin
            res_d.status = ST_NONE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      ptr_q     <= '0;
      base_q    <= '0;
      res_vld_q <= 1'b0;
      found_q   <= 1'b0;
      p0_vld_q  <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      res_vld_q <= res_vld_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (found_clr) begin
        found_q <= 1'b0;
      end else if (best_upd) begin
        found_q <= 1'b1;
      end
      p0_vld_q <= (state_q == S_SCAN);
      p1_vld_q <= p0_vld_q;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status != ST_DISPATCHED)
      |-> (result_o.chosen_id == '0) && (result_o.rating == '0))
    else $error("non-dispatch beat carries id or rating");

  a_accept_followup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || result_valid_o)
    else $error("accepted item neither in progress nor answered");

  a_scan_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !result_valid_o && !mem_we)
    else $error("result or write during dispatch scan");

  a_commit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) && res_vld_d |-> !pipe_busy && !best_upd)
    else $error("dispatch committed before rating pipeline drained");

endmodule
